/* rtl/core/lsc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared constants and types for the lidar spherical to Cartesian converter.
// ----------------------------------------------------------------------------
package lsc_pkg;

    localparam int RANGE_BITS_DEF  = 18;
    localparam int ANGLE_BITS_DEF  = 16;
    localparam int MAX_COLUMNS_DEF = 4096;

    localparam int CORDIC_STEPS = 24;
    localparam int CW           = 34;   // cordic x/y datapath width
    localparam int ZW           = 33;   // cordic phase width
    localparam int COORD_W      = 19;
    localparam int COORD_LIMIT  = 262143;
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    localparam logic [2:0] REG_COLS   = 3'd0;
    localparam logic [2:0] REG_H_START = 3'd1;
    localparam logic [2:0] REG_H_STEP = 3'd2;
    localparam logic [2:0] REG_V_START = 3'd3;
    localparam logic [2:0] REG_V_STEP = 3'd4;

    function automatic logic signed [ZW-1:0] atan_turn(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:  a = 33'sd536870912;
            1:  a = 33'sd316933406;
            2:  a = 33'sd167458907;
            3:  a = 33'sd85004756;
            4:  a = 33'sd42667331;
            5:  a = 33'sd21354465;
            6:  a = 33'sd10679838;
            7:  a = 33'sd5340245;
            8:  a = 33'sd2670163;
            9:  a = 33'sd1335087;
            10: a = 33'sd667544;
            11: a = 33'sd333772;
            12: a = 33'sd166886;
            13: a = 33'sd83443;
            14: a = 33'sd41722;
            15: a = 33'sd20861;
            16: a = 33'sd10430;
            17: a = 33'sd5215;
            18: a = 33'sd2608;
            19: a = 33'sd1304;
            20: a = 33'sd652;
            21: a = 33'sd326;
            22: a = 33'sd163;
            23: a = 33'sd81;
            default: a = '0;
        endcase
        return a;
    endfunction

    // word handed from one cordic cell to the next
    typedef struct packed {
        logic                 vld;
        logic signed [CW-1:0] hx;
        logic signed [CW-1:0] hy;
        logic signed [ZW-1:0] hz;
        logic signed [CW-1:0] vx;
        logic signed [CW-1:0] vy;
        logic signed [ZW-1:0] vz;
        logic                 hflip;
        logic                 vflip;
        logic                 inv;
        logic [11:0]          col;
        logic [15:0]          row;
        logic [31:0]          rng;
    } t_cell;

endpackage
`default_nettype wire

/* rtl/core/lsc_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_cell
// One CORDIC micro-rotation for both the horizontal and vertical angles.
// ----------------------------------------------------------------------------
module lsc_cell #(
    parameter int STEP = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire lsc_pkg::t_cell i_word,
    output lsc_pkg::t_cell     o_word
);
    localparam logic signed [lsc_pkg::ZW-1:0] ATAN = lsc_pkg::atan_turn(STEP);

    lsc_pkg::t_cell n_word;
    lsc_pkg::t_cell r_word;

    always_comb begin
        n_word = i_word;
        if (i_word.hz >= 0) begin
            n_word.hx = i_word.hx - (i_word.hy >>> STEP);
            n_word.hy = i_word.hy + (i_word.hx >>> STEP);
            n_word.hz = i_word.hz - ATAN;
        end else begin
            n_word.hx = i_word.hx + (i_word.hy >>> STEP);
            n_word.hy = i_word.hy - (i_word.hx >>> STEP);
            n_word.hz = i_word.hz + ATAN;
        end
        if (i_word.vz >= 0) begin
            n_word.vx = i_word.vx - (i_word.vy >>> STEP);
            n_word.vy = i_word.vy + (i_word.vx >>> STEP);
            n_word.vz = i_word.vz - ATAN;
        end else begin
            n_word.vx = i_word.vx + (i_word.vy >>> STEP);
            n_word.vy = i_word.vy - (i_word.vx >>> STEP);
            n_word.vz = i_word.vz + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end else if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;
endmodule
`default_nettype wire

/* rtl/core/lsc_scale.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_scale
// Range scaling: t = r cos v, then x, y, z with rounding and saturation.
// ----------------------------------------------------------------------------
module lsc_scale (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire lsc_pkg::t_cell i_word,
    output logic               o_vld,
    output logic [87:0]        o_data    // x, y, z, point_valid, column, row
);
    localparam int CW = lsc_pkg::CW;

    // stage A: cos/sin after flip, r*cos v and r*sin v
    logic                 r_av, r_ainv;
    logic signed [CW-1:0] r_ch, r_sh;
    logic signed [66:0]   r_rcv, r_rsv;
    logic [11:0]          r_acol;
    logic [15:0]          r_arow;
    // stage B: t, saturated z and the x/y product operands
    logic                 r_bv, r_binv;
    logic signed [35:0]   r_t;
    logic signed [CW-1:0] r_bch, r_bsh;
    logic signed [lsc_pkg::COORD_W-1:0] r_bz;
    logic [11:0]          r_bcol;
    logic [15:0]          r_brow;
    // stage C
    logic                 r_cv;
    logic [87:0]          r_out;

    logic signed [CW-1:0] n_ch, n_sh, n_cv, n_sv;
    logic signed [66:0]   n_rcv_r, n_rsv_r;
    logic signed [71:0]   n_x, n_y;

    function automatic logic signed [lsc_pkg::COORD_W-1:0] sat(input logic signed [71:0] v);
        if (v > 72'sd262143) return 19'sd262143;
        if (v < -72'sd262143) return -19'sd262143;
        return v[lsc_pkg::COORD_W-1:0];
    endfunction

    always_comb begin
        n_ch = i_word.hflip ? -i_word.hx : i_word.hx;
        n_sh = i_word.hflip ? -i_word.hy : i_word.hy;
        n_cv = i_word.vflip ? -i_word.vx : i_word.vx;
        n_sv = i_word.vflip ? -i_word.vy : i_word.vy;
        n_rcv_r = (r_rcv + 67'sd536870912) >>> 30;
        n_rsv_r = (r_rsv + 67'sd536870912) >>> 30;
        n_x = ((72'(r_t) * 72'(r_bch)) + 72'sd536870912) >>> 30;
        n_y = ((72'(r_t) * 72'(r_bsh)) + 72'sd536870912) >>> 30;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
            r_bv <= 1'b0;
            r_cv <= 1'b0;
        end else if (i_en) begin
            r_av <= i_word.vld;
            r_bv <= r_av;
            r_cv <= r_bv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ainv <= i_word.inv;
            r_ch   <= n_ch;
            r_sh   <= n_sh;
            r_rcv  <= 67'($signed({1'b0, i_word.rng})) * 67'(n_cv);
            r_rsv  <= 67'($signed({1'b0, i_word.rng})) * 67'(n_sv);
            r_acol <= i_word.col;
            r_arow <= i_word.row;

            r_binv <= r_ainv;
            r_t    <= n_rcv_r[35:0];
            r_bch  <= r_ch;
            r_bsh  <= r_sh;
            r_bz   <= sat(72'(n_rsv_r));
            r_bcol <= r_acol;
            r_brow <= r_arow;

            if (r_binv) begin
                r_out <= {2'd0, r_brow, r_bcol, 1'b0, 57'd0};
            end else begin
                r_out <= {2'd0, r_brow, r_bcol, 1'b1, r_bz, sat(n_y), sat(n_x)};
            end
        end
    end

    assign o_vld    = r_cv;
    assign o_data   = r_out;
endmodule
`default_nettype wire

/* rtl/core/lidar_spherical_to_cartesian.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_spherical_to_cartesian
// Lidar range samples to Cartesian points via a chain of CORDIC cells.
// ----------------------------------------------------------------------------
// Pipeline: 1 input register, 24 CORDIC cells, 3 scaling stages.
// Throughput: one word per cycle; the whole chain stalls while the output
// word waits, so the rate is set by the output handshake, with every stage advancing as one.
// Reset: synchronous active low; counters, accumulators, config registers and valid bits
// clear, columns_per_row resets to 1.
module lidar_spherical_to_cartesian #(
    parameter int RANGE_BITS  = lsc_pkg::RANGE_BITS_DEF,
    parameter int ANGLE_BITS  = lsc_pkg::ANGLE_BITS_DEF,
    parameter int MAX_COLUMNS = lsc_pkg::MAX_COLUMNS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [(RANGE_BITS + 7) / 8 * 8 - 1:0] s_axis_tdata,  // range_mm
    input  wire logic [1:0]  s_axis_tuser,  // range_invalid, frame_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata,  // x_mm, y_mm, z_mm, point_valid, column, row
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    localparam int ZW = lsc_pkg::ZW;
    localparam int COLW = $clog2(MAX_COLUMNS + 1);
    localparam int CNTW = $clog2(MAX_COLUMNS);

    logic [12:0] r_cols;
    logic [15:0] r_hs, r_hst, r_vs, r_vst;
    logic [CNTW-1:0] r_col;
    logic [15:0] r_row;
    logic [ANGLE_BITS-1:0] r_hacc, r_vacc;

    logic en, acc;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign acc = s_axis_tvalid && en;
    assign o_cfg_ready = 1'b1;

    function automatic logic [ANGLE_BITS-1:0] rang(input logic [15:0] v);
        return ANGLE_BITS'($signed(v));
    endfunction

    logic [CNTW-1:0] c_col; logic [15:0] c_row;
    logic [ANGLE_BITS-1:0] c_h, c_v;
    logic [COLW-1:0] c_cols;
    logic [31:0] c_p_h, c_p_v;
    lsc_pkg::t_cell w_in;
    lsc_pkg::t_cell w_chain [0:lsc_pkg::CORDIC_STEPS];

    always_comb begin
        c_col = r_col; c_row = r_row; c_h = r_hacc; c_v = r_vacc;
        if (s_axis_tuser[1]) begin
            c_col = '0; c_row = '0; c_h = rang(r_hs); c_v = rang(r_vs);
        end
        if (r_cols == 13'd0) c_cols = COLW'(1);
        else if (32'(r_cols) > MAX_COLUMNS) c_cols = COLW'(MAX_COLUMNS);
        else c_cols = COLW'(r_cols);
        c_p_h = 32'(c_h) << (32 - ANGLE_BITS);
        c_p_v = 32'(c_v) << (32 - ANGLE_BITS);
        w_in = '0;
        w_in.vld = 1'b1;
        w_in.inv = s_axis_tuser[0];
        w_in.col = 12'(c_col);
        w_in.row = c_row;
        w_in.rng = 32'(s_axis_tdata[RANGE_BITS-1:0]);
        w_in.hx = lsc_pkg::CORDIC_GAIN_Q30;
        w_in.vx = lsc_pkg::CORDIC_GAIN_Q30;
        w_in.hflip = c_p_h[31] ^ c_p_h[30];
        w_in.vflip = c_p_v[31] ^ c_p_v[30];
        w_in.hz = ZW'($signed(c_p_h + (w_in.hflip ? 32'h8000_0000 : 32'h0)));
        w_in.vz = ZW'($signed(c_p_v + (w_in.vflip ? 32'h8000_0000 : 32'h0)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= 13'd1; r_hs <= '0; r_hst <= '0; r_vs <= '0; r_vst <= '0;
            r_col <= '0; r_row <= '0; r_hacc <= '0; r_vacc <= '0;
            w_chain[0].vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    lsc_pkg::REG_COLS:    r_cols <= 13'(i_cfg_data);
                    lsc_pkg::REG_H_START: r_hs <= i_cfg_data;
                    lsc_pkg::REG_H_STEP:  r_hst <= i_cfg_data;
                    lsc_pkg::REG_V_START: r_vs <= i_cfg_data;
                    lsc_pkg::REG_V_STEP:  r_vst <= i_cfg_data;
                    default: ;
                endcase
            end
            if (en) w_chain[0] <= acc ? w_in : '0;
            if (acc) begin
                if (32'(c_col) + 1 >= 32'(c_cols)) begin
                    r_col <= '0; r_row <= c_row + 16'd1;
                    r_hacc <= rang(r_hs); r_vacc <= c_v + rang(r_vst);
                end else begin
                    r_col <= c_col + CNTW'(1); r_hacc <= c_h + rang(r_hst);
                    r_vacc <= c_v; r_row <= c_row;
                end
            end
        end
    end

    for (genvar g = 0; g < lsc_pkg::CORDIC_STEPS; g++) begin : g_cell
        lsc_cell #(.STEP(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_word(w_chain[g]), .o_word(w_chain[g+1])
        );
    end

    lsc_scale u_scale (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_word(w_chain[lsc_pkg::CORDIC_STEPS]),
        .o_vld(m_axis_tvalid), .o_data(m_axis_tdata)
    );

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("stall leak");
    a_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[57] |-> m_axis_tdata[56:0] == 57'd0)
        else $error("invalid point nonzero");
endmodule
`default_nettype wire
